>>> src/rv64alu_pkg.sv
// Shared types, opcodes and sizes for the RV64I execute block.
`default_nettype none
package rv64alu_pkg;

    localparam int XLEN      = 64;
    localparam int REG_COUNT = 32;
    localparam int REG_AW    = $clog2(REG_COUNT);
    localparam int IDX_W     = 5;
    localparam int OPC_W     = 5;
    localparam int IMM_W     = 32;
    localparam int Q_DEPTH   = 2;
    localparam int Q_AW      = $clog2(Q_DEPTH);

    localparam logic [5:0] SHAMT64_MASK = 6'b111111;
    localparam logic [4:0] SHAMT32_MASK = 5'b11111;

    localparam logic [OPC_W-1:0] OP_ADDI  = 5'd0;
    localparam logic [OPC_W-1:0] OP_SLTI  = 5'd1;
    localparam logic [OPC_W-1:0] OP_SLTIU = 5'd2;
    localparam logic [OPC_W-1:0] OP_XORI  = 5'd3;
    localparam logic [OPC_W-1:0] OP_ORI   = 5'd4;
    localparam logic [OPC_W-1:0] OP_ANDI  = 5'd5;
    localparam logic [OPC_W-1:0] OP_SLLI  = 5'd6;
    localparam logic [OPC_W-1:0] OP_SRLI  = 5'd7;
    localparam logic [OPC_W-1:0] OP_SRAI  = 5'd8;
    localparam logic [OPC_W-1:0] OP_LUI   = 5'd9;
    localparam logic [OPC_W-1:0] OP_AUIPC = 5'd10;
    localparam logic [OPC_W-1:0] OP_ADD   = 5'd11;
    localparam logic [OPC_W-1:0] OP_SUB   = 5'd12;
    localparam logic [OPC_W-1:0] OP_SLL   = 5'd13;
    localparam logic [OPC_W-1:0] OP_SLT   = 5'd14;
    localparam logic [OPC_W-1:0] OP_SLTU  = 5'd15;
    localparam logic [OPC_W-1:0] OP_XOR   = 5'd16;
    localparam logic [OPC_W-1:0] OP_SRL   = 5'd17;
    localparam logic [OPC_W-1:0] OP_SRA   = 5'd18;
    localparam logic [OPC_W-1:0] OP_OR    = 5'd19;
    localparam logic [OPC_W-1:0] OP_AND   = 5'd20;
    localparam logic [OPC_W-1:0] OP_ADDIW = 5'd21;
    localparam logic [OPC_W-1:0] OP_SLLIW = 5'd22;
    localparam logic [OPC_W-1:0] OP_SRLIW = 5'd23;
    localparam logic [OPC_W-1:0] OP_SRAIW = 5'd24;
    localparam logic [OPC_W-1:0] OP_ADDW  = 5'd25;
    localparam logic [OPC_W-1:0] OP_SUBW  = 5'd26;
    localparam logic [OPC_W-1:0] OP_SLLW  = 5'd27;
    localparam logic [OPC_W-1:0] OP_SRLW  = 5'd28;
    localparam logic [OPC_W-1:0] OP_SRAW  = 5'd29;

    typedef enum logic [3:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_SLT,
        ALU_SLTU,
        ALU_XOR,
        ALU_OR,
        ALU_AND,
        ALU_SLL,
        ALU_SRL,
        ALU_SRA,
        ALU_PASS
    } t_alu_op;

    // Decoded request as it travels from front to back
    typedef struct packed {
        t_alu_op          alu_op;
        logic             use_imm;
        logic             use_pc;
        logic             is_word;
        logic             wr_en;
        logic [IDX_W-1:0] rd;
        logic [IDX_W-1:0] rs1;
        logic [IDX_W-1:0] rs2;
        logic [IMM_W-1:0] imm;
        logic [XLEN-1:0]  pc;
    } t_uop;

    function automatic logic idx_in_range(input logic [IDX_W-1:0] idx);
        return (int'(idx) < REG_COUNT);
    endfunction

    // x0 and out-of-range indices never hold data
    function automatic logic idx_live(input logic [IDX_W-1:0] idx);
        return (idx != '0) && idx_in_range(idx);
    endfunction

endpackage
`default_nettype wire

>>> src/rv64alu_front.sv
// Front end: takes requests and decodes the opcode into an ALU control word.
`default_nettype none
module rv64alu_front (
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire logic [rv64alu_pkg::OPC_W-1:0]  i_opcode,
    input  wire logic [rv64alu_pkg::IDX_W-1:0]  i_dest_index,
    input  wire logic [rv64alu_pkg::IDX_W-1:0]  i_src1_index,
    input  wire logic [rv64alu_pkg::IDX_W-1:0]  i_src2_index,
    input  wire logic [rv64alu_pkg::IMM_W-1:0]  i_immediate,
    input  wire logic [rv64alu_pkg::XLEN-1:0]   i_instr_pc,
    output logic                                o_push_valid,
    input  wire logic                           i_push_ready,
    output rv64alu_pkg::t_uop                   o_uop
);
    import rv64alu_pkg::*;

    logic op_known;

    assign o_in_ready   = i_push_ready;
    assign o_push_valid = i_in_valid;

    always_comb begin
        op_known        = 1'b1;
        o_uop.alu_op    = ALU_ADD;
        o_uop.use_imm   = 1'b0;
        o_uop.use_pc    = 1'b0;
        o_uop.is_word   = 1'b0;
        o_uop.rd        = i_dest_index;
        o_uop.rs1       = i_src1_index;
        o_uop.rs2       = i_src2_index;
        o_uop.imm       = i_immediate;
        o_uop.pc        = i_instr_pc;
        case (i_opcode)
            OP_ADDI:  begin o_uop.use_imm = 1'b1; end
            OP_SLTI:  begin o_uop.use_imm = 1'b1; o_uop.alu_op = ALU_SLT;  end
            OP_SLTIU: begin o_uop.use_imm = 1'b1; o_uop.alu_op = ALU_SLTU; end
            OP_XORI:  begin o_uop.use_imm = 1'b1; o_uop.alu_op = ALU_XOR;  end
            OP_ORI:   begin o_uop.use_imm = 1'b1; o_uop.alu_op = ALU_OR;   end
            OP_ANDI:  begin o_uop.use_imm = 1'b1; o_uop.alu_op = ALU_AND;  end
            OP_SLLI:  begin o_uop.use_imm = 1'b1; o_uop.alu_op = ALU_SLL;  end
            OP_SRLI:  begin o_uop.use_imm = 1'b1; o_uop.alu_op = ALU_SRL;  end
            OP_SRAI:  begin o_uop.use_imm = 1'b1; o_uop.alu_op = ALU_SRA;  end
            OP_LUI:   begin o_uop.use_imm = 1'b1; o_uop.alu_op = ALU_PASS; end
            OP_AUIPC: begin o_uop.use_imm = 1'b1; o_uop.use_pc = 1'b1;    end
            OP_ADD:   begin o_uop.alu_op = ALU_ADD;  end
            OP_SUB:   begin o_uop.alu_op = ALU_SUB;  end
            OP_SLL:   begin o_uop.alu_op = ALU_SLL;  end
            OP_SLT:   begin o_uop.alu_op = ALU_SLT;  end
            OP_SLTU:  begin o_uop.alu_op = ALU_SLTU; end
            OP_XOR:   begin o_uop.alu_op = ALU_XOR;  end
            OP_SRL:   begin o_uop.alu_op = ALU_SRL;  end
            OP_SRA:   begin o_uop.alu_op = ALU_SRA;  end
            OP_OR:    begin o_uop.alu_op = ALU_OR;   end
            OP_AND:   begin o_uop.alu_op = ALU_AND;  end
            OP_ADDIW: begin o_uop.use_imm = 1'b1; o_uop.is_word = 1'b1; end
            OP_SLLIW: begin
                o_uop.use_imm = 1'b1; o_uop.is_word = 1'b1; o_uop.alu_op = ALU_SLL;
            end
            OP_SRLIW: begin
                o_uop.use_imm = 1'b1; o_uop.is_word = 1'b1; o_uop.alu_op = ALU_SRL;
            end
            OP_SRAIW: begin
                o_uop.use_imm = 1'b1; o_uop.is_word = 1'b1; o_uop.alu_op = ALU_SRA;
            end
            OP_ADDW:  begin o_uop.is_word = 1'b1; end
            OP_SUBW:  begin o_uop.is_word = 1'b1; o_uop.alu_op = ALU_SUB; end
            OP_SLLW:  begin o_uop.is_word = 1'b1; o_uop.alu_op = ALU_SLL; end
            OP_SRLW:  begin o_uop.is_word = 1'b1; o_uop.alu_op = ALU_SRL; end
            OP_SRAW:  begin o_uop.is_word = 1'b1; o_uop.alu_op = ALU_SRA; end
            default:  begin op_known = 1'b0; end
        endcase
        // unused opcodes and dead destinations produce a zero result, no write
        o_uop.wr_en = op_known && idx_live(i_dest_index);
    end

endmodule
`default_nettype wire

>>> src/rv64alu_queue.sv
// Two-entry queue of decoded requests between front and back.
`default_nettype none
module rv64alu_queue (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push_valid,
    output logic                    o_push_ready,
    input  wire rv64alu_pkg::t_uop  i_uop,
    output logic                    o_pop_valid,
    input  wire logic               i_pop_ready,
    output rv64alu_pkg::t_uop       o_uop
);
    import rv64alu_pkg::*;

    t_uop             r_slots [Q_DEPTH];
    logic [Q_AW-1:0]  r_wr_ptr;
    logic [Q_AW-1:0]  r_rd_ptr;
    logic [Q_AW:0]    r_count;
    logic [Q_AW-1:0]  n_wr_ptr;
    logic [Q_AW-1:0]  n_rd_ptr;
    logic             push;
    logic             pop;

    assign o_push_ready = (r_count != (Q_AW+1)'(Q_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_uop        = r_slots[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    assign n_wr_ptr = (r_wr_ptr == Q_AW'(Q_DEPTH-1)) ? '0 : r_wr_ptr + 1'b1;
    assign n_rd_ptr = (r_rd_ptr == Q_AW'(Q_DEPTH-1)) ? '0 : r_rd_ptr + 1'b1;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slots[r_wr_ptr] <= i_uop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

>>> src/rv64alu_back.sv
// Back end: register file read, bypass, ALU, write-back and output register.
`default_nettype none
module rv64alu_back (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_uop_valid,
    output logic                                o_uop_ready,
    input  wire rv64alu_pkg::t_uop              i_uop,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output logic [rv64alu_pkg::IDX_W-1:0]       o_written_index,
    output logic [rv64alu_pkg::XLEN-1:0]        o_written_value
);
    import rv64alu_pkg::*;

    logic [XLEN-1:0]      r_regs [REG_COUNT];
    logic [REG_COUNT-1:0] r_reg_valid;

    logic                 r_ex_valid;
    t_uop                 r_ex_uop;
    logic [XLEN-1:0]      r_rs1_data;
    logic [XLEN-1:0]      r_rs2_data;
    logic                 r_rs1_ok;
    logic                 r_rs2_ok;

    logic                 r_fwd_valid;
    logic [IDX_W-1:0]     r_fwd_idx;
    logic [XLEN-1:0]      r_fwd_data;

    logic                 r_out_valid;
    logic [IDX_W-1:0]     r_out_index;
    logic [XLEN-1:0]      r_out_value;

    logic                 take;
    logic                 ex_advance;
    logic                 wr;
    logic [XLEN-1:0]      rs1_val;
    logic [XLEN-1:0]      rs2_val;
    logic [XLEN-1:0]      op_a;
    logic [XLEN-1:0]      op_b;
    logic [XLEN-1:0]      sum;
    logic [XLEN-1:0]      diff;
    logic [XLEN-1:0]      sll_res;
    logic [XLEN-1:0]      srl_src;
    logic [XLEN-1:0]      srl_res;
    logic [XLEN-1:0]      sra_src;
    logic [XLEN-1:0]      sra_res;
    logic [5:0]           shamt;
    logic [XLEN-1:0]      alu_res;
    logic [XLEN-1:0]      ex_res;
    logic [XLEN-1:0]      wb_value;

    assign ex_advance  = r_ex_valid && (!r_out_valid || i_out_ready);
    assign o_uop_ready = !r_ex_valid || ex_advance;
    assign take        = i_uop_valid && o_uop_ready;
    assign wr          = ex_advance && r_ex_uop.wr_en;

    assign o_out_valid     = r_out_valid;
    assign o_written_index = r_out_index;
    assign o_written_value = r_out_value;

    // register file: one write, two registered reads
    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_regs[r_ex_uop.rd[REG_AW-1:0]] <= wb_value;
        end
        if (take) begin
            r_rs1_data <= r_regs[i_uop.rs1[REG_AW-1:0]];
            r_rs2_data <= r_regs[i_uop.rs2[REG_AW-1:0]];
            r_rs1_ok   <= idx_live(i_uop.rs1) && r_reg_valid[i_uop.rs1[REG_AW-1:0]];
            r_rs2_ok   <= idx_live(i_uop.rs2) && r_reg_valid[i_uop.rs2[REG_AW-1:0]];
            r_ex_uop   <= i_uop;
        end
        if (wr) begin
            r_fwd_idx  <= r_ex_uop.rd;
            r_fwd_data <= wb_value;
        end
        if (ex_advance) begin
            r_out_index <= r_ex_uop.rd;
            r_out_value <= wb_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reg_valid <= '0;
            r_ex_valid  <= 1'b0;
            r_fwd_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (wr) begin
                r_reg_valid[r_ex_uop.rd[REG_AW-1:0]] <= 1'b1;
                r_fwd_valid                           <= 1'b1;
            end
            if (take) begin
                r_ex_valid <= 1'b1;
            end else if (ex_advance) begin
                r_ex_valid <= 1'b0;
            end
            if (ex_advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // last write may have landed on the same edge as this request's read
    always_comb begin
        if (r_fwd_valid && (r_fwd_idx == r_ex_uop.rs1)) begin
            rs1_val = r_fwd_data;
        end else begin
            rs1_val = r_rs1_ok ? r_rs1_data : '0;
        end
        if (r_fwd_valid && (r_fwd_idx == r_ex_uop.rs2)) begin
            rs2_val = r_fwd_data;
        end else begin
            rs2_val = r_rs2_ok ? r_rs2_data : '0;
        end
    end

    assign op_a = r_ex_uop.use_pc ? r_ex_uop.pc : rs1_val;
    assign op_b = r_ex_uop.use_imm ? {{(XLEN-IMM_W){r_ex_uop.imm[IMM_W-1]}}, r_ex_uop.imm}
                                   : rs2_val;

    assign sum   = op_a + op_b;
    assign diff  = op_a - op_b;
    assign shamt = r_ex_uop.is_word ? {1'b0, op_b[4:0] & SHAMT32_MASK}
                                    : (op_b[5:0] & SHAMT64_MASK);

    assign sll_res = op_a << shamt;
    assign srl_src = r_ex_uop.is_word ? {32'b0, op_a[31:0]} : op_a;
    assign srl_res = srl_src >> shamt;
    assign sra_src = r_ex_uop.is_word ? {{32{op_a[31]}}, op_a[31:0]} : op_a;
    assign sra_res = $signed(sra_src) >>> shamt;

    always_comb begin
        case (r_ex_uop.alu_op)
            ALU_ADD:  alu_res = sum;
            ALU_SUB:  alu_res = diff;
            ALU_SLT:  alu_res = {63'b0, ($signed(op_a) < $signed(op_b))};
            ALU_SLTU: alu_res = {63'b0, (op_a < op_b)};
            ALU_XOR:  alu_res = op_a ^ op_b;
            ALU_OR:   alu_res = op_a | op_b;
            ALU_AND:  alu_res = op_a & op_b;
            ALU_SLL:  alu_res = sll_res;
            ALU_SRL:  alu_res = srl_res;
            ALU_SRA:  alu_res = sra_res;
            ALU_PASS: alu_res = op_b;
            default:  alu_res = '0;
        endcase
    end

    assign ex_res   = r_ex_uop.is_word ? {{32{alu_res[31]}}, alu_res[31:0]} : alu_res;
    assign wb_value = r_ex_uop.wr_en ? ex_res : '0;

endmodule
`default_nettype wire

>>> src/rv64i_integer_alu_with_regfile_top.sv
// Top level of the RV64I integer execute block with its register file.
// A request passes through the queue, the execute stage and the output register, in that order.
// Throughput: one request per cycle unless output stalls; the queue holds two requests,
// the execute stage and output register one each; back-to-back dependencies are bypassed.
// Reset: i_rst_n synchronous, active low; empties queue and pipeline and marks
// every register as zero through per-entry valid bits, so no clearing pass.
`default_nettype none
module rv64i_integer_alu_with_regfile_top (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire logic [rv64alu_pkg::OPC_W-1:0]  i_opcode,
    input  wire logic [rv64alu_pkg::IDX_W-1:0]  i_dest_index,
    input  wire logic [rv64alu_pkg::IDX_W-1:0]  i_src1_index,
    input  wire logic [rv64alu_pkg::IDX_W-1:0]  i_src2_index,
    input  wire logic [rv64alu_pkg::IMM_W-1:0]  i_immediate,
    input  wire logic [rv64alu_pkg::XLEN-1:0]   i_instr_pc,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output logic [rv64alu_pkg::IDX_W-1:0]       o_written_index,
    output logic [rv64alu_pkg::XLEN-1:0]        o_written_value
);
    import rv64alu_pkg::*;

    // decoded request, front to queue
    t_uop fe_uop;
    logic fe_valid;
    logic fe_ready;

    // queue to back end
    t_uop q_uop;
    logic q_valid;
    logic q_ready;

    // front: decode opcode into ALU op, operand selects, word flag and write enable
    rv64alu_front u_front (
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_opcode     (i_opcode),
        .i_dest_index (i_dest_index),
        .i_src1_index (i_src1_index),
        .i_src2_index (i_src2_index),
        .i_immediate  (i_immediate),
        .i_instr_pc   (i_instr_pc),
        .o_push_valid (fe_valid),
        .i_push_ready (fe_ready),
        .o_uop        (fe_uop)
    );

    // short queue so the input side keeps taking requests while the output stalls
    rv64alu_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (fe_valid),
        .o_push_ready (fe_ready),
        .i_uop        (fe_uop),
        .o_pop_valid  (q_valid),
        .i_pop_ready  (q_ready),
        .o_uop        (q_uop)
    );

    // back: register read on pop, execute with bypass, write-back and result register
    rv64alu_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_uop_valid     (q_valid),
        .o_uop_ready     (q_ready),
        .i_uop           (q_uop),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_written_index (o_written_index),
        .o_written_value (o_written_value)
    );

endmodule
`default_nettype wire

>>> bench/tb_rv64i_integer_alu_with_regfile_top.sv
// Self-checking bench for the RV64I execute block: directed rows, then random requests.
`timescale 1ns / 100ps
module tb_rv64i_integer_alu_with_regfile_top;
    import rv64alu_pkg::*;

    // Opcodes 30 and 31 have no package name; both must behave as no-ops
    localparam logic [OPC_W-1:0] OP_RSVD30 = 5'd30;
    localparam logic [OPC_W-1:0] OP_RSVD31 = 5'd31;

    localparam int RANDOM_REQS = 1900;
    // Worst case allows for the random sink stalls per request plus the long hold-off
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_AT     = 700;  // result count at which the sink holds off
    localparam int HOLD_LEN    = 300;
    localparam int DRAIN_WAIT  = 8;    // leave some slack after the last expected result

    // One stimulus row; typed rows carry a value read straight off the spec
    typedef struct packed {
        logic [OPC_W-1:0] opc;
        logic [IDX_W-1:0] rd;
        logic [IDX_W-1:0] rs1;
        logic [IDX_W-1:0] rs2;
        logic [IMM_W-1:0] imm;
        logic [XLEN-1:0]  pc;
        logic             typed;
        logic [XLEN-1:0]  value;
    } t_row;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic [XLEN-1:0]  val;
    } t_writeback;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_ready;
    logic [OPC_W-1:0]    i_opcode = '0;
    logic [IDX_W-1:0]    i_dest_index = '0;
    logic [IDX_W-1:0]    i_src1_index = '0;
    logic [IDX_W-1:0]    i_src2_index = '0;
    logic [IMM_W-1:0]    i_immediate = '0;
    logic [XLEN-1:0]     i_instr_pc = '0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    logic [IDX_W-1:0]    o_written_index;
    logic [XLEN-1:0]     o_written_value;

    // Travel alongside the payload so the monitor knows which rows are typed
    logic                row_typed = 1'b0;
    logic [XLEN-1:0]     row_value = '0;

    logic [XLEN-1:0]     reg_shadow [REG_COUNT];
    t_writeback          writeback_queue [$];
    t_row                rows [$];
    int                  mismatches = 0;
    int                  results_checked = 0;
    int                  requests_sent = 0;
    int                  cycles = 0;
    bit [31:0]           opc_seen = '0;

    rv64i_integer_alu_with_regfile_top u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_opcode        (i_opcode),
        .i_dest_index    (i_dest_index),
        .i_src1_index    (i_src1_index),
        .i_src2_index    (i_src2_index),
        .i_immediate     (i_immediate),
        .i_instr_pc      (i_instr_pc),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_written_index (o_written_index),
        .o_written_value (o_written_value)
    );

    always #1 i_clk = ~i_clk;

    // Watchdog: a hung handshake ends the run here
    always @(posedge i_clk) begin
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // x0 and indices past the file never hold data
    function automatic bit holds_data(input logic [IDX_W-1:0] idx);
        return (idx != '0) && (int'(idx) < REG_COUNT);
    endfunction

    function automatic logic [XLEN-1:0] read_shadow(input logic [IDX_W-1:0] idx);
        return holds_data(idx) ? reg_shadow[idx] : '0;
    endfunction

    // Executes one request on the shadow register file and returns its write-back
    function automatic t_writeback execute_on_shadow(input t_row rq);
        logic [XLEN-1:0]        a;
        logic [XLEN-1:0]        b;
        logic [XLEN-1:0]        imm64;
        logic [XLEN-1:0]        r;
        logic signed [XLEN-1:0] a_s;
        logic signed [31:0]     lo_s;
        logic [31:0]            w;
        bit                     defined;
        t_writeback             wb;
        a       = read_shadow(rq.rs1);
        b       = read_shadow(rq.rs2);
        imm64   = {{32{rq.imm[31]}}, rq.imm};
        a_s     = a;
        lo_s    = a[31:0];
        r       = '0;
        w       = '0;
        defined = 1'b1;
        case (rq.opc)
            OP_ADDI:  r = a + imm64;
            OP_SLTI:  r = ($signed(a) < $signed(imm64)) ? 64'd1 : 64'd0;
            OP_SLTIU: r = (a < imm64) ? 64'd1 : 64'd0;
            OP_XORI:  r = a ^ imm64;
            OP_ORI:   r = a | imm64;
            OP_ANDI:  r = a & imm64;
            OP_SLLI:  r = a << rq.imm[5:0];
            OP_SRLI:  r = a >> rq.imm[5:0];
            OP_SRAI:  r = a_s >>> rq.imm[5:0];
            OP_LUI:   r = imm64;
            OP_AUIPC: r = rq.pc + imm64;
            OP_ADD:   r = a + b;
            OP_SUB:   r = a - b;
            OP_SLL:   r = a << b[5:0];
            OP_SLT:   r = ($signed(a) < $signed(b)) ? 64'd1 : 64'd0;
            OP_SLTU:  r = (a < b) ? 64'd1 : 64'd0;
            OP_XOR:   r = a ^ b;
            OP_SRL:   r = a >> b[5:0];
            OP_SRA:   r = a_s >>> b[5:0];
            OP_OR:    r = a | b;
            OP_AND:   r = a & b;
            OP_ADDIW: w = a[31:0] + rq.imm;
            OP_SLLIW: w = a[31:0] << rq.imm[4:0];
            OP_SRLIW: w = a[31:0] >> rq.imm[4:0];
            OP_SRAIW: w = lo_s >>> rq.imm[4:0];
            OP_ADDW:  w = a[31:0] + b[31:0];
            OP_SUBW:  w = a[31:0] - b[31:0];
            OP_SLLW:  w = a[31:0] << b[4:0];
            OP_SRLW:  w = a[31:0] >> b[4:0];
            OP_SRAW:  w = lo_s >>> b[4:0];
            default:  defined = 1'b0;
        endcase
        // Word forms sign-extend their 32-bit result
        if (rq.opc >= OP_ADDIW && rq.opc <= OP_SRAW)
            r = {{32{w[31]}}, w};
        if (!defined || !holds_data(rq.rd))
            r = '0;
        else
            reg_shadow[rq.rd] = r;
        wb.idx = rq.rd;
        wb.val = r;
        return wb;
    endfunction

    function automatic t_row mk(input logic [OPC_W-1:0] opc, input logic [IDX_W-1:0] rd,
                                input logic [IDX_W-1:0] rs1, input logic [IDX_W-1:0] rs2,
                                input logic [IMM_W-1:0] imm, input logic [XLEN-1:0] pc,
                                input logic typed, input logic [XLEN-1:0] value);
        t_row t;
        t.opc = opc; t.rd = rd; t.rs1 = rs1; t.rs2 = rs2;
        t.imm = imm; t.pc = pc; t.typed = typed; t.value = value;
        return t;
    endfunction

    // Random request; in tight mode the indices crowd onto x0..x3 so that
    // back-to-back dependencies hit the bypass paths
    function automatic t_row random_request(input bit tight);
        t_row        t;
        int unsigned pick;
        t.opc = ($urandom_range(0, 31) == 0) ? OPC_W'(OP_RSVD30 + $urandom_range(0, 1))
                                             : OPC_W'($urandom_range(0, 29));
        t.rd  = tight ? IDX_W'($urandom_range(0, 3)) : IDX_W'($urandom_range(0, 31));
        t.rs1 = tight ? IDX_W'($urandom_range(0, 3)) : IDX_W'($urandom_range(0, 31));
        t.rs2 = tight ? IDX_W'($urandom_range(0, 3)) : IDX_W'($urandom_range(0, 31));
        pick = $urandom_range(0, 7);
        case (pick)
            0:       t.imm = '0;
            1:       t.imm = 32'hFFFF_FFFF;
            2:       t.imm = 32'h7FFF_FFFF;
            3:       t.imm = 32'h8000_0000;
            4:       t.imm = $urandom_range(0, 63);
            default: t.imm = $urandom;
        endcase
        // Upper immediates normally arrive pre-shifted, but not always
        if ((t.opc == OP_LUI || t.opc == OP_AUIPC) && $urandom_range(0, 3) != 0)
            t.imm[11:0] = '0;
        pick = $urandom_range(0, 9);
        t.pc = (pick == 0) ? '0 : (pick == 1) ? '1 : {$urandom, $urandom};
        t.typed = 1'b0;
        t.value = '0;
        return t;
    endfunction

    // Offers one request and returns at the edge that accepts it. Valid is
    // only lowered when a gap precedes the request, so it never toggles within one step.
    task automatic offer(input t_row rq, input int unsigned gap);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_opcode     <= rq.opc;
        i_dest_index <= rq.rd;
        i_src1_index <= rq.rs1;
        i_src2_index <= rq.rs2;
        i_immediate  <= rq.imm;
        i_instr_pc   <= rq.pc;
        row_typed    <= rq.typed;
        row_value    <= rq.value;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        requests_sent++;
    endtask

    // Monitor: results are checked before the request of the same edge is
    // predicted; both see pre-edge values only
    always @(posedge i_clk) begin
        t_writeback exp_wb;
        t_row       rq;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                results_checked++;
                if (writeback_queue.size() == 0) begin
                    $error("result with no request outstanding: index %0d value %h",
                           o_written_index, o_written_value);
                    mismatches++;
                end else begin
                    exp_wb = writeback_queue.pop_front();
                    if (o_written_index !== exp_wb.idx) begin
                        $error("written_index: expected %0d, got %0d",
                               exp_wb.idx, o_written_index);
                        mismatches++;
                    end
                    if (o_written_value !== exp_wb.val) begin
                        $error("written_value: expected %h, got %h",
                               exp_wb.val, o_written_value);
                        mismatches++;
                    end
                end
            end
            if (i_in_valid && o_in_ready) begin
                rq = mk(i_opcode, i_dest_index, i_src1_index, i_src2_index,
                        i_immediate, i_instr_pc, row_typed, row_value);
                exp_wb = execute_on_shadow(rq);
                // Typed rows override the prediction; the shadow still moves on
                if (row_typed)
                    exp_wb.val = row_value;
                writeback_queue.push_back(exp_wb);
                opc_seen[i_opcode] = 1'b1;
            end
        end
    end

    // Sink: random stall per result, stretches without stalls, and one long
    // hold-off so the block backs up and drops o_in_ready
    initial begin
        int unsigned stall;
        int          taken;
        taken = 0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = ((taken % 450) < 100) ? 0 : $urandom_range(0, 9);
            if (taken == HOLD_AT)
                stall = HOLD_LEN;
            if (stall != 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
            taken++;
        end
    end

    // Source, then drain and verdict
    initial begin
        int unsigned gap;
        int          n;
        int          directed_count;
        for (int i = 0; i < REG_COUNT; i++)
            reg_shadow[i] = '0;

        // Register setup first, then every operation; x4 = 1 << 63, x2 = -1
        rows.push_back(mk(OP_ADD,   5,  1,  2, 32'h0,         '0, 1'b1, 64'h0));
        rows.push_back(mk(OP_LUI,   1,  0,  0, 32'h8000_0000, '0, 1'b1,
                          64'hFFFF_FFFF_8000_0000));
        rows.push_back(mk(OP_ADDI,  2,  0,  0, 32'hFFFF_FFFF, '0, 1'b1, '1));
        rows.push_back(mk(OP_AUIPC, 3,  0,  0, 32'h7FFF_F000, '1, 1'b1,
                          64'h0000_0000_7FFF_EFFF));
        // shift amount from bits 5:0 only
        rows.push_back(mk(OP_SLLI,  4,  2,  0, 32'hFFFF_FFFF, '0, 1'b1,
                          64'h8000_0000_0000_0000));
        // destination x0 reports zero
        rows.push_back(mk(OP_ORI,   0,  2,  0, 32'h0001_2345, '0, 1'b1, 64'h0));
        // unused opcodes write nothing
        rows.push_back(mk(OP_RSVD30, 9, 2,  2, 32'hFFFF_FFFF, '1, 1'b1, 64'h0));
        rows.push_back(mk(OP_RSVD31, 31, 2, 2, 32'hFFFF_FFFF, '1, 1'b1, 64'h0));
        rows.push_back(mk(OP_XORI,  6,  1,  0, 32'hFFFF_FFFF, '0, 1'b0, '0));
        rows.push_back(mk(OP_ANDI,  7,  2,  0, 32'h0000_07FF, '0, 1'b0, '0));
        rows.push_back(mk(OP_SRAI,  8,  4,  0, 32'hFFFF_FFBF, '0, 1'b0, '0));
        rows.push_back(mk(OP_SRLI,  9,  4,  0, 32'h0000_0FC1, '0, 1'b0, '0));
        rows.push_back(mk(OP_SLTI,  10, 2,  0, 32'h0,         '0, 1'b0, '0));
        rows.push_back(mk(OP_SLTIU, 11, 0,  0, 32'hFFFF_FFFF, '0, 1'b0, '0));
        rows.push_back(mk(OP_SUB,   12, 0,  4, 32'h0,         '0, 1'b0, '0));
        rows.push_back(mk(OP_SLL,   13, 2,  2, 32'h0,         '0, 1'b0, '0));
        rows.push_back(mk(OP_SLT,   14, 4,  6, 32'h0,         '0, 1'b0, '0));
        rows.push_back(mk(OP_SLTU,  15, 4,  6, 32'h0,         '0, 1'b0, '0));
        rows.push_back(mk(OP_XOR,   16, 1,  6, 32'h0,         '0, 1'b0, '0));
        rows.push_back(mk(OP_SRL,   17, 4,  7, 32'h0,         '0, 1'b0, '0));
        rows.push_back(mk(OP_SRA,   18, 4,  8, 32'h0,         '0, 1'b0, '0));
        rows.push_back(mk(OP_OR,    19, 1,  6, 32'h0,         '0, 1'b0, '0));
        rows.push_back(mk(OP_AND,   20, 2,  3, 32'h0,         '0, 1'b0, '0));
        rows.push_back(mk(OP_ADDIW, 21, 6,  0, 32'h1,         '0, 1'b0, '0));
        rows.push_back(mk(OP_SLLIW, 22, 2,  0, 32'h0000_001F, '0, 1'b0, '0));
        rows.push_back(mk(OP_SRLIW, 23, 1,  0, 32'hFFFF_FFFF, '0, 1'b0, '0));
        rows.push_back(mk(OP_SRAIW, 24, 1,  0, 32'h0000_001F, '0, 1'b0, '0));
        rows.push_back(mk(OP_ADDW,  25, 6,  6, 32'h0,         '0, 1'b0, '0));
        rows.push_back(mk(OP_SUBW,  26, 0,  1, 32'h0,         '0, 1'b0, '0));
        rows.push_back(mk(OP_SLLW,  27, 6,  2, 32'h0,         '0, 1'b0, '0));
        rows.push_back(mk(OP_SRLW,  28, 2,  9, 32'h0,         '0, 1'b0, '0));
        rows.push_back(mk(OP_SRAW,  29, 1,  7, 32'h0,         '0, 1'b0, '0));
        // x31 must still be zero after the no-op aimed at it
        rows.push_back(mk(OP_ADD,   31, 31, 2, 32'h0,         '0, 1'b0, '0));
        directed_count = rows.size();

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i])
            offer(rows[i], $urandom_range(0, 3));

        // Random part: idle-free stretches every few hundred requests
        for (n = 0; n < RANDOM_REQS; n++) begin
            gap = ((n % 500) < 120) ? 0 : $urandom_range(0, 9);
            offer(random_request(((n / 64) % 3) == 0), gap);
        end
        i_in_valid <= 1'b0;

        while (writeback_queue.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("Run: %0d requests (%0d directed), %0d results checked, %0d opcodes seen",
                 requests_sent, directed_count, results_checked, $countones(opc_seen));
        $display("Sink held off for %0d cycles once; %0d mismatches", HOLD_LEN, mismatches);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
